// File: rtl/clbs_pkg.sv
package clbs_pkg;

  localparam int DEF_NUM_PARTICLES = 4096;
  localparam int DEF_CELLS_PER_BOX = 1024;
  localparam int DEF_NUM_BOXES     = 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic STAT_DONE      = 1'b0;
  localparam logic STAT_NOT_FOUND = 1'b1;

  localparam int OP_W = 3;

  // classified request kinds handed from front to engine
  typedef enum logic [OP_W-1:0] {
    OP_NOP,
    OP_FAIL,
    OP_ADD,
    OP_REMOVE,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ISSUE,
    S_ADD_WR,
    S_RM_HEAD,
    S_RM_WALK,
    S_SWEEP,
    S_DONE
  } state_t;

  // head store address width
  function automatic int slot_width(int cpb, int nb);
    return $clog2(cpb * nb);
  endfunction

  // particle index plus end marker
  function automatic int val_width(int np);
    return $clog2(np + 1);
  endfunction

  function automatic int req_width(int np, int cpb, int nb);
    return OP_W + slot_width(cpb, nb) + val_width(np);
  endfunction

endpackage

// File: rtl/clbs_queue.sv
module clbs_queue #(
  parameter int W     = 8,
  parameter int DEPTH = clbs_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid,
  output logic         full
);
  import clbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign valid   = (count_r != '0);
  assign full    = (count_r == CW'(DEPTH));
  assign dout    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/clbs_front.sv
module clbs_front #(
  parameter int NUM_PARTICLES = clbs_pkg::DEF_NUM_PARTICLES,
  parameter int CELLS_PER_BOX = clbs_pkg::DEF_CELLS_PER_BOX,
  parameter int NUM_BOXES     = clbs_pkg::DEF_NUM_BOXES
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_box,
  input  logic [9:0]  in_cell_req,
  input  logic [11:0] in_particle,
  input  logic        init_busy,
  input  logic        q_full,
  output logic        q_push,
  output logic [clbs_pkg::req_width(NUM_PARTICLES, CELLS_PER_BOX, NUM_BOXES)-1:0] q_req
);
  import clbs_pkg::*;

  localparam int HW = slot_width(CELLS_PER_BOX, NUM_BOXES);
  localparam int PW = val_width(NUM_PARTICLES);

  typedef struct packed {
    op_t           op;
    logic [HW-1:0] slot;
    logic [PW-1:0] p;
  } req_t;

  req_t          req;
  logic          box_ok, cell_ok, part_ok;
  logic [HW-1:0] base;

  assign box_ok  = 32'(in_box) < 32'(NUM_BOXES);
  assign cell_ok = 32'(in_cell_req) < 32'(CELLS_PER_BOX);
  assign part_ok = 32'(in_particle) < 32'(NUM_PARTICLES);
  assign base    = in_box ? HW'(CELLS_PER_BOX) : '0;

  always_comb begin
    req.op   = OP_NOP;
    req.slot = base + HW'(in_cell_req);
    req.p    = PW'(in_particle);
    case (in_command)
      CMD_ADD: begin
        req.op = (box_ok && cell_ok && part_ok) ? OP_ADD : OP_NOP;
      end
      CMD_REMOVE: begin
        req.op = (box_ok && cell_ok && part_ok) ? OP_REMOVE : OP_FAIL;
      end
      CMD_CLEAR: begin
        req.op   = box_ok ? OP_CLEAR : OP_NOP;
        req.slot = base;
      end
      default: begin
        req.op = OP_NOP;
      end
    endcase
  end

  assign in_stall = init_busy || q_full;
  assign q_push   = in_valid && !in_stall;
  assign q_req    = req;

endmodule

// File: rtl/clbs_engine.sv
module clbs_engine #(
  parameter int NUM_PARTICLES = clbs_pkg::DEF_NUM_PARTICLES,
  parameter int CELLS_PER_BOX = clbs_pkg::DEF_CELLS_PER_BOX,
  parameter int NUM_BOXES     = clbs_pkg::DEF_NUM_BOXES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  logic [clbs_pkg::req_width(NUM_PARTICLES, CELLS_PER_BOX, NUM_BOXES)-1:0] q_dout,
  output logic q_pop,
  output logic init_busy,
  output logic out_valid,
  input  logic out_stall,
  output logic out_status
);
  import clbs_pkg::*;

  localparam int HW         = slot_width(CELLS_PER_BOX, NUM_BOXES);
  localparam int PW         = val_width(NUM_PARTICLES);
  localparam int IW         = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int SW         = $clog2(NUM_PARTICLES + 1);
  localparam int HEAD_DEPTH = NUM_BOXES * CELLS_PER_BOX;
  localparam logic [PW-1:0] END_MARK = PW'(NUM_PARTICLES);

  typedef struct packed {
    op_t           op;
    logic [HW-1:0] slot;
    logic [PW-1:0] p;
  } req_t;

  logic [PW-1:0] head_mem [HEAD_DEPTH];
  logic [PW-1:0] next_mem [NUM_PARTICLES];

  state_t        state_r, state_nxt;
  req_t          q_req;
  req_t          req_r, req_nxt;
  logic [PW-1:0] at_r, at_nxt;
  logic [PW-1:0] pnext_r, pnext_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [HW-1:0] sweep_r, sweep_nxt;
  logic [HW-1:0] sweep_end_r, sweep_end_nxt;
  logic          stat_r, stat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;

  logic [PW-1:0] head_rd_r, next_rd_r;
  logic          head_we, next_we;
  logic [HW-1:0] head_wa, head_ra;
  logic [PW-1:0] head_wd, next_wd;
  logic [IW-1:0] next_wa, next_ra;

  logic head_hit, head_is_p, walk_hit, walk_more, sweep_last, out_free;

  assign q_req      = q_dout;
  assign head_hit   = (head_rd_r == req_r.p);
  assign head_is_p  = (head_rd_r < END_MARK);
  assign walk_hit   = (next_rd_r == req_r.p);
  // the walk visits at most NUM_PARTICLES links
  assign walk_more  = (next_rd_r < END_MARK) && (steps_r < SW'(NUM_PARTICLES - 1));
  assign sweep_last = (sweep_r == sweep_end_r);
  assign out_free   = !out_valid_r || !out_stall;

  assign init_busy  = (state_r == S_INIT);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_req.op)
            OP_ADD, OP_REMOVE: state_nxt = S_ISSUE;
            OP_CLEAR:          state_nxt = S_SWEEP;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_ISSUE: begin
        state_nxt = (req_r.op == OP_ADD) ? S_ADD_WR : S_RM_HEAD;
      end
      S_ADD_WR: begin
        state_nxt = S_DONE;
      end
      S_RM_HEAD: begin
        state_nxt = (head_hit || !head_is_p) ? S_DONE : S_RM_WALK;
      end
      S_RM_WALK: begin
        state_nxt = (walk_hit || !walk_more) ? S_DONE : S_RM_WALK;
      end
      S_SWEEP: begin
        if (sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_nxt        = req_r;
    at_nxt         = at_r;
    pnext_nxt      = pnext_r;
    steps_nxt      = steps_r;
    sweep_nxt      = sweep_r;
    sweep_end_nxt  = sweep_end_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    head_we        = 1'b0;
    head_wa        = req_r.slot;
    head_wd        = req_r.p;
    head_ra        = req_r.slot;
    next_we        = 1'b0;
    next_wa        = req_r.p[IW-1:0];
    next_wd        = head_rd_r;
    next_ra        = req_r.p[IW-1:0];
    case (state_r)
      S_INIT, S_SWEEP: begin
        head_we  = 1'b1;
        head_wa  = sweep_r;
        head_wd  = END_MARK;
        stat_nxt = STAT_DONE;
        if (!sweep_last) sweep_nxt = sweep_r + HW'(1);
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          req_nxt       = q_req;
          stat_nxt      = (q_req.op == OP_FAIL) ? STAT_NOT_FOUND : STAT_DONE;
          sweep_nxt     = q_req.slot;
          sweep_end_nxt = q_req.slot + HW'(CELLS_PER_BOX - 1);
        end
      end
      S_ISSUE: begin
        // head of the cell and, for a remove, the successor of the particle
        head_ra = req_r.slot;
        next_ra = req_r.p[IW-1:0];
      end
      S_ADD_WR: begin
        next_we  = 1'b1;
        next_wa  = req_r.p[IW-1:0];
        next_wd  = head_rd_r;
        head_we  = 1'b1;
        head_wa  = req_r.slot;
        head_wd  = req_r.p;
        stat_nxt = STAT_DONE;
      end
      S_RM_HEAD: begin
        pnext_nxt = next_rd_r;
        if (head_hit) begin
          head_we  = 1'b1;
          head_wa  = req_r.slot;
          head_wd  = next_rd_r;
          stat_nxt = STAT_DONE;
        end else if (!head_is_p) begin
          stat_nxt = STAT_NOT_FOUND;
        end else begin
          at_nxt    = head_rd_r;
          steps_nxt = '0;
          next_ra   = head_rd_r[IW-1:0];
        end
      end
      S_RM_WALK: begin
        if (walk_hit) begin
          next_we  = 1'b1;
          next_wa  = at_r[IW-1:0];
          next_wd  = pnext_r;
          stat_nxt = STAT_DONE;
        end else if (walk_more) begin
          at_nxt    = next_rd_r;
          steps_nxt = steps_r + SW'(1);
          next_ra   = next_rd_r[IW-1:0];
        end else begin
          stat_nxt = STAT_NOT_FOUND;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
        end
      end
      default: begin
        stat_nxt = stat_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
      sweep_end_r <= HW'(HEAD_DEPTH - 1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_r     <= sweep_nxt;
      sweep_end_r <= sweep_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    at_r         <= at_nxt;
    pnext_r      <= pnext_nxt;
    steps_r      <= steps_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_r <= next_mem[next_ra];
  end

endmodule

// File: rtl/cell_list_bin_store.sv
// Linked-cell particle list. A head store (one entry per box and cell) and a next store
// (one entry per particle) hold the chains. Requests are add, remove and clear-box; every
// request returns one status (1 = remove found no such particle in the given cell, or its
// fields were out of range). Each store has one read and one write port. An add reads the
// cell head and links the particle in front of it; a remove checks the head and then walks
// the chain link by link; a clear writes the end marker into every cell of the box; an
// out-of-range request goes straight to its status. A two-entry queue lets new requests be
// taken while the engine works. After reset all NUM_BOXES * CELLS_PER_BOX head entries
// (2048 by default) are swept to the end marker, with in_stall held high.
module cell_list_bin_store #(
  parameter int NUM_PARTICLES = clbs_pkg::DEF_NUM_PARTICLES,
  parameter int CELLS_PER_BOX = clbs_pkg::DEF_CELLS_PER_BOX,
  parameter int NUM_BOXES     = clbs_pkg::DEF_NUM_BOXES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_box,
  input  logic [9:0]  in_cell_req,
  input  logic [11:0] in_particle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status
);
  import clbs_pkg::*;

  localparam int RW = req_width(NUM_PARTICLES, CELLS_PER_BOX, NUM_BOXES);

  logic          init_busy;
  logic          q_push, q_pop, q_valid, q_full;
  logic [RW-1:0] q_din, q_dout;

  clbs_front #(
    .NUM_PARTICLES (NUM_PARTICLES),
    .CELLS_PER_BOX (CELLS_PER_BOX),
    .NUM_BOXES     (NUM_BOXES)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_box      (in_box),
    .in_cell_req (in_cell_req),
    .in_particle (in_particle),
    .init_busy   (init_busy),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_req       (q_din)
  );

  clbs_queue #(
    .W     (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid),
    .full  (q_full)
  );

  clbs_engine #(
    .NUM_PARTICLES (NUM_PARTICLES),
    .CELLS_PER_BOX (CELLS_PER_BOX),
    .NUM_BOXES     (NUM_BOXES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status)
  );

  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> in_stall)
    else $error("request accepted during head store sweep");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into a full queue");

  a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
    !init_busy |=> !init_busy)
    else $error("head store sweep restarted without reset");

endmodule
